>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define PBF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("port property failed");

// Check that a condition is followed by an expression in the next cycle
`define PBF_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("port sequence failed");

`endif

>>> design/pbf_pkg.sv
// ---------------------------------------------------------------------------
// pbf_pkg
// Constants and controller/datapath interface types of the bracket filter.
// ---------------------------------------------------------------------------
package pbf_pkg;

   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] OPEN_BR  = 8'h28;
   localparam logic [BYTE_W-1:0] CLOSE_BR = 8'h29;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;            // store the accepted input item
      logic back_init;       // start the backward pass at the last stored entry
      logic rd_en;           // read the buffer at the walk index
      logic back_step;       // resolve one entry of the backward pass
      logic emit_step;       // advance the walk index of the emit pass
      logic out_load;        // put the entry just read into the output register
      logic out_empty_load;  // put the empty-string item into the output register
      logic clear;           // end of string, return counters to zero
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic idx_zero;        // walk index is at the first entry
      logic idx_at_end;      // walk index is at the last stored entry
      logic any_kept_next;   // some entry is kept, including the one resolved now
      logic rd_keep;         // entry just read is kept
      logic out_free;        // output register can take an item this cycle
   } stat_type;

endpackage

>>> design/pbf_ctrl.sv
// ---------------------------------------------------------------------------
// pbf_ctrl
// Sequencer for load, backward pass and emit pass of the bracket filter.
// ---------------------------------------------------------------------------
module pbf_ctrl
   import pbf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     req_tlast,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_LOAD   = 6'b000001,
      S_BK_RD  = 6'b000010,
      S_BK_CHK = 6'b000100,
      S_EM_RD  = 6'b001000,
      S_EM_CHK = 6'b010000,
      S_EMPTY  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_LOAD);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.back_init = 1'b1;
                  state_in      = S_BK_RD;
               end
            end
         end
         S_BK_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_BK_CHK;
         end
         S_BK_CHK: begin
            cmd.back_step = 1'b1;
            if (!stat.idx_zero) begin
               state_in = S_BK_RD;
            end else if (stat.any_kept_next) begin
               state_in = S_EM_RD;
            end else begin
               state_in = S_EMPTY;
            end
         end
         S_EM_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EM_CHK;
         end
         S_EM_CHK: begin
            // Skip dropped entries, hold kept ones until the output frees up
            if (!stat.rd_keep || stat.out_free) begin
               cmd.out_load = stat.rd_keep;
               if (stat.idx_at_end) begin
                  cmd.clear = 1'b1;
                  state_in  = S_LOAD;
               end else begin
                  cmd.emit_step = 1'b1;
                  state_in      = S_EM_RD;
               end
            end
         end
         S_EMPTY: begin
            if (stat.out_free) begin
               cmd.out_empty_load = 1'b1;
               cmd.clear          = 1'b1;
               state_in           = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/pbf_dp.sv
// ---------------------------------------------------------------------------
// pbf_dp
// Character buffer, bracket counters, walk index and output register.
// ---------------------------------------------------------------------------
module pbf_dp
   import pbf_pkg::*;
#(
   parameter int MAX_LEN = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [BYTE_W-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,
   output logic              rsp_tlast,
   output logic [1:0]        rsp_tuser
);

   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int CNT_W  = $clog2(MAX_LEN + 1);

   // Buffer entry: drop mark above the character
   logic [BYTE_W:0]       mem [MAX_LEN];
   logic [BYTE_W:0]       rd_data_ff;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [BYTE_W:0]       wr_data;

   logic [CNT_W-1:0]      count_ff,  count_in;
   logic [CNT_W-1:0]      depth_ff,  depth_in;
   logic [CNT_W-1:0]      closes_ff, closes_in;
   logic                  ovf_ff,    ovf_in;
   logic [ADDR_W-1:0]     idx_ff,    idx_in;
   logic [ADDR_W-1:0]     lkept_ff,  lkept_in;
   logic                  kept_ff,   kept_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_data_ff,  rsp_data_in;
   logic                  rsp_last_ff,  rsp_last_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_ovf_ff,   rsp_ovf_in;

   logic                  full;
   logic                  in_open;
   logic                  in_close;
   logic                  in_drop;
   logic                  rd_mark;
   logic [BYTE_W-1:0]     rd_byte;
   logic                  rd_open;
   logic                  rd_close;
   logic                  drop_open;
   logic                  keep_now;
   logic                  out_free;

   assign full     = (count_ff == CNT_W'(MAX_LEN));
   assign in_open  = (req_tdata == OPEN_BR);
   assign in_close = (req_tdata == CLOSE_BR);
   assign in_drop  = in_close && (depth_ff == '0);

   assign rd_mark   = rd_data_ff[BYTE_W];
   assign rd_byte   = rd_data_ff[BYTE_W-1:0];
   assign rd_open   = (rd_byte == OPEN_BR);
   assign rd_close  = (rd_byte == CLOSE_BR);
   assign drop_open = !rd_mark && rd_open && (closes_ff == '0);
   assign keep_now  = !rd_mark && !drop_open;

   assign out_free = !rsp_valid_ff || rsp_tready;

   assign stat.idx_zero      = (idx_ff == '0);
   assign stat.idx_at_end    = ({1'b0, idx_ff} == CNT_W'(count_ff - 1'b1));
   assign stat.any_kept_next = kept_ff || keep_now;
   assign stat.rd_keep       = !rd_mark;
   assign stat.out_free      = out_free;

   // Buffer write port: stored input item, or a late mark on an open bracket
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[ADDR_W-1:0];
      wr_data = {in_drop, req_tdata};
      if (cmd.load && !full) begin
         wr_en = 1'b1;
      end else if (cmd.back_step && drop_open) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = {1'b1, rd_byte};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   // Counters, walk index and last kept entry
   always_comb begin
      count_in  = count_ff;
      depth_in  = depth_ff;
      closes_in = closes_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      lkept_in  = lkept_ff;
      kept_in   = kept_ff;

      if (cmd.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            if (in_open) begin
               depth_in = depth_ff + 1'b1;
            end else if (in_close && !in_drop) begin
               depth_in = depth_ff - 1'b1;
            end
         end
      end

      // Start the backward pass at the entry stored last
      if (cmd.back_init) begin
         closes_in = '0;
         kept_in   = 1'b0;
         idx_in    = full ? ADDR_W'(count_ff - 1'b1) : count_ff[ADDR_W-1:0];
      end

      if (cmd.back_step) begin
         if (!rd_mark && rd_close) begin
            closes_in = closes_ff + 1'b1;
         end else if (!rd_mark && rd_open && (closes_ff != '0)) begin
            closes_in = closes_ff - 1'b1;
         end
         if (keep_now && !kept_ff) begin
            kept_in  = 1'b1;
            lkept_in = idx_ff;
         end
         if (idx_ff != '0) begin
            idx_in = idx_ff - 1'b1;
         end
      end

      if (cmd.emit_step) begin
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.clear) begin
         count_in = '0;
         depth_in = '0;
         ovf_in   = 1'b0;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rd_byte;
         rsp_last_in  = (idx_ff == lkept_ff);
         rsp_empty_in = 1'b0;
         rsp_ovf_in   = ovf_ff;
      end else if (cmd.out_empty_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_last_in  = 1'b1;
         rsp_empty_in = 1'b1;
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         depth_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         depth_ff     <= depth_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      closes_ff    <= closes_in;
      idx_ff       <= idx_in;
      lkept_ff     <= lkept_in;
      kept_ff      <= kept_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_empty_ff};

endmodule

>>> design/paren_balance_filter.sv
// Loading takes one input item per cycle. After the last byte, a backward pass
// walks the stored bytes through the single read port of the character buffer,
// then, if any byte is kept, an emit pass walks them again through that port
// and waits on output stalls; no new string is taken until it is done.
// Reset (synchronous, active high) empties the buffer counts and the output;
// buffer contents are not cleared and are never read before being written.
// ---------------------------------------------------------------------------
// paren_balance_filter
// Removes the fewest brackets needed to leave a string balanced.
// ---------------------------------------------------------------------------
module paren_balance_filter
   import pbf_pkg::*;
#(
   parameter int MAX_LEN = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast,
   output logic [1:0]        rsp_tuser    // [0] out_empty, [1] out_overflow
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer
   pbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Buffer and counters
   pbf_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> design/pbf_checker.sv
// ---------------------------------------------------------------------------
// pbf_checker
// Port-level checks of the bracket filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pbf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser
);

   // A stalled result item holds
   `PBF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable({rsp_tdata, rsp_tlast, rsp_tuser}))

   // The empty-string item is the last item of its string
   `PBF_ASSERT(a_empty_last, clock, reset, !(rsp_tvalid && rsp_tuser[0]) || rsp_tlast)

   // The empty-string item carries a zero byte
   `PBF_ASSERT(a_empty_zero, clock, reset, !(rsp_tvalid && rsp_tuser[0]) || (rsp_tdata == 8'h00))

   // No new string is taken while the emit pass is still under way
   `PBF_ASSERT(a_no_load_in_emit, clock, reset, !(rsp_tvalid && !rsp_tlast) || !req_tready)

endmodule

bind paren_balance_filter pbf_checker u_checker (.*);

>>> bench/paren_balance_filter_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// paren_balance_filter_test
// Streams strings into the bracket filter and checks every kept character,
// the last and empty marks and the overflow flag against a scoreboard that
// resolves unmatched brackets on its own. Both stream sides idle at random,
// and the result side holds off once for a long stretch.
// ---------------------------------------------------------------------------
module paren_balance_filter_test
   import pbf_pkg::*;
();

   localparam int DEPTH = 64;

   // One expected result item
   typedef struct {
      logic [BYTE_W-1:0] ch;
      logic              last;
      logic              empty;
      logic              overflow;
   } kept_item_type;

   // Tracks the string being loaded and queues the kept characters it yields
   class bracket_scoreboard;
      logic [BYTE_W-1:0] text_buf [DEPTH];
      bit                drop_buf [DEPTH];
      int                stored_len;
      int unsigned       open_count;
      bit                overflowed;
      kept_item_type     expected_q[$];
      int unsigned       errors;

      function new();
         stored_len = 0;
         open_count = 0;
         overflowed = 1'b0;
         errors     = 0;
      endfunction

      // Load one accepted input item; on the last one resolve and queue results
      function void note_input(logic [BYTE_W-1:0] ch, logic last);
         int            i;
         int            last_kept;
         int unsigned   closes;
         bit            mark;
         kept_item_type item;
         if (stored_len < DEPTH) begin
            mark = 1'b0;
            if (ch == OPEN_BR) begin
               open_count = (open_count + 1) & 7'h7F;
            end else if (ch == CLOSE_BR) begin
               if (open_count > 0) open_count--;
               else mark = 1'b1;
            end
            text_buf[stored_len] = ch;
            drop_buf[stored_len] = mark;
            stored_len++;
         end else begin
            overflowed = 1'b1;
         end
         if (!last) return;

         // Walk backward and drop each open bracket with no close after it
         closes = 0;
         for (i = stored_len - 1; i >= 0; i--) begin
            if (!drop_buf[i]) begin
               if (text_buf[i] == CLOSE_BR) begin
                  closes++;
               end else if (text_buf[i] == OPEN_BR) begin
                  if (closes > 0) closes--;
                  else drop_buf[i] = 1'b1;
               end
            end
         end

         // Queue the kept characters in order, the final one marked last
         last_kept = -1;
         for (i = 0; i < stored_len; i++) begin
            if (!drop_buf[i]) last_kept = i;
         end
         for (i = 0; i < stored_len; i++) begin
            if (!drop_buf[i]) begin
               item.ch       = text_buf[i];
               item.last     = (i == last_kept);
               item.empty    = 1'b0;
               item.overflow = overflowed;
               expected_q.push_back(item);
            end
         end
         if (last_kept < 0) begin
            item.ch       = '0;
            item.last     = 1'b1;
            item.empty    = 1'b1;
            item.overflow = overflowed;
            expected_q.push_back(item);
         end
         stored_len = 0;
         open_count = 0;
         overflowed = 1'b0;
      endfunction

      // Compare one accepted result item with the oldest expectation
      function void check_result(logic [BYTE_W-1:0] ch, logic last, logic [1:0] user);
         kept_item_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item, actual ch %h last %b user %b",
                     $time, ch, last, user);
            return;
         end
         want = expected_q.pop_front();
         if (ch !== want.ch) begin
            errors++;
            $display("%0t: ch mismatch, expected %h actual %h", $time, want.ch, ch);
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: last mismatch, expected %b actual %b", $time, want.last, last);
         end
         if (user[0] !== want.empty) begin
            errors++;
            $display("%0t: empty mismatch, expected %b actual %b",
                     $time, want.empty, user[0]);
         end
         if (user[1] !== want.overflow) begin
            errors++;
            $display("%0t: overflow mismatch, expected %b actual %b",
                     $time, want.overflow, user[1]);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata  = '0;   // [7:0] in_byte
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [BYTE_W-1:0] rsp_tdata;        // [7:0] out_byte
   logic              rsp_tlast;
   logic [1:0]        rsp_tuser;        // [0] out_empty, [1] out_overflow

   bracket_scoreboard board = new();
   bit                sender_burst = 1'b0;

   paren_balance_filter #(.MAX_LEN(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // End the run if it hangs
   initial begin
      #10000000;
      $display("Verification failed");
      $finish;
   end

   // Offer one item after a random gap and hold it until accepted
   task automatic send_byte(input logic [BYTE_W-1:0] ch, input logic last);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (sender_burst || r < 60) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_input(ch, last);
   endtask

   task automatic send_literal(input string s);
      int i;
      sender_burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // Send a string of random brackets and characters, leaning one way at random
   task automatic send_random_string(input int len);
      int                i;
      int                r;
      int                lean;
      logic [BYTE_W-1:0] ch;
      lean = $urandom_range(0, 2);
      sender_burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 5) ch = "*";
         else if (r < 25) ch = BYTE_W'($urandom_range(0, 255));
         else if (r < 25 + 25 + 15 * lean) ch = OPEN_BR;
         else ch = CLOSE_BR;
         send_byte(ch, i == len - 1);
      end
   endtask

   // Result side: random stalls, stretches without stalls, one long hold-off
   initial begin
      int hold;
      int taken;
      bit quiet;
      bit pressed;
      hold    = 0;
      taken   = 0;
      quiet   = 1'b0;
      pressed = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
            taken++;
         end
         if ($urandom_range(0, 63) == 0) quiet = ~quiet;
         if (!pressed && taken == 12) begin
            pressed = 1'b1;
            hold    = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!quiet && !reset && $urandom_range(0, 3) == 0) begin
            hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Main stimulus
   initial begin
      int sent;
      int len;
      int r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed strings: lone brackets, matched pairs, stray closes and opens, plain characters
      send_literal("(");
      send_literal(")");
      send_literal("()");
      send_literal("*");
      send_literal("a)(");
      send_literal("(()");
      send_literal("())(");
      send_literal(")()(");
      send_literal("((");
      sender_burst = 1'b0;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // Exactly full buffer, then a string that overflows it
      send_random_string(DEPTH);
      send_random_string(DEPTH + 2);

      // Random strings, mostly short, a few long enough to overflow
      sent = 0;
      while (sent < 100) begin
         r = $urandom_range(0, 99);
         if (r < 80) len = $urandom_range(1, 10);
         else if (r < 96) len = $urandom_range(11, 30);
         else len = $urandom_range(60, 70);
         send_random_string(len);
         sent += len;
      end
      req_tvalid <= 1'b0;

      // Drain the results, then keep watching for stray result items
      while (board.expected_q.size() > 0) @(posedge clock);
      repeat (6 * DEPTH) @(posedge clock);

      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
